// ===== rtl/lpm_pkg.sv =====
// Shared types and constants for the noisy mean block.
package lpm_pkg;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   localparam logic [31:0] EPS_RESET = 32'd65536;

   typedef enum logic [0:0] {
      REG_EPSILON = 1'b0,
      REG_RANGE   = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic start;       // begin finish sequence for the latched set
      logic rsp_taken;   // result handed off
   } dp_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } dp_status_type;
endpackage

// ===== rtl/lpm_if.sv =====
// Valid/ready channel interfaces for the noisy mean block.
interface lpm_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] sample;
   logic        last_sample;
   logic [31:0] random_word;
   modport source (output valid, sample, last_sample, random_word, input ready);
   modport sink (input valid, sample, last_sample, random_word, output ready);
endinterface

interface lpm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [59:0] noisy_mean;
   logic [47:0]        plain_mean;
   logic [12:0]        sample_count;
   logic               count_overflow;
   modport source (output valid, noisy_mean, plain_mean, sample_count, count_overflow,
                   input ready);
   modport sink (input valid, noisy_mean, plain_mean, sample_count, count_overflow,
                 output ready);
endinterface

interface lpm_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/lpm_datapath.sv =====
// Datapath: sample accumulator, divider, log unit, noise divider and output.
module lpm_datapath
   import lpm_pkg::*;
#(
   parameter int MAX_SAMPLES = 4096,
   parameter int CW = $clog2(MAX_SAMPLES + 1),
   parameter int SW = 32 + $clog2(MAX_SAMPLES)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          acc_en,
   input  logic [31:0]   sample,
   input  logic          last_sample,
   input  logic [31:0]   random_word,
   input  logic [31:0]   epsilon_q16,
   input  logic [31:0]   value_range,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic signed [59:0] noisy_mean,
   output logic [47:0]   plain_mean,
   output logic [12:0]   sample_count,
   output logic          count_overflow
);
   typedef enum logic [2:0] {
      P_IDLE, P_MEAN, P_LOG, P_LMUL, P_PMUL, P_NDIV, P_SUM, P_DONE
   } phase_type;

   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SAMPLES);
   localparam logic [61:0] NOISE_CAP = 62'd1 << 61;
   localparam int DW = SW + 16;

   phase_type phase_ff, phase_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          ovf_ff, ovf_in;

   // latched set
   logic [CW-1:0] fcnt_ff, fcnt_in;
   logic          fovf_ff, fovf_in;
   logic [31:0]   rw_ff, rw_in;

   // shared restoring divider
   logic [95:0] num_ff, num_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] den_ff, den_in;
   logic [61:0] quo_ff, quo_in;
   logic [6:0]  step_ff, step_in;
   logic        capped_ff, capped_in;

   logic [47:0] mean_ff, mean_in;
   logic [4:0]  lint_ff, lint_in;
   logic [31:0] lfrac_ff, lfrac_in;
   logic [32:0] y_ff, y_in;
   logic [36:0] e2_ff, e2_in;
   logic [36:0] l_ff, l_in;
   logic [63:0] p0_ff, p0_in, p1_ff, p1_in;
   logic [61:0] noise_ff, noise_in;
   logic signed [59:0] out_ff, out_in;

   logic [64:0] rem_sh;
   logic [65:0] ysq;
   logic [31:0] xval;
   logic [4:0]  msb;
   logic [68:0] lsum;
   logic [95:0] prod;
   logic signed [62:0] total;

   always_comb begin
      xval = 32'h8000_0000 - {1'b0, rw_ff[30:0]};
      msb = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (xval[i]) msb = 5'(i);
      end
   end

   always_comb begin
      phase_in = phase_ff;
      sum_in = sum_ff; cnt_in = cnt_ff; ovf_in = ovf_ff;
      fcnt_in = fcnt_ff; fovf_in = fovf_ff; rw_in = rw_ff;
      num_in = num_ff; rem_in = rem_ff; den_in = den_ff; quo_in = quo_ff;
      step_in = step_ff; capped_in = capped_ff;
      mean_in = mean_ff; lint_in = lint_ff; lfrac_in = lfrac_ff; y_in = y_ff;
      e2_in = e2_ff; l_in = l_ff; p0_in = p0_ff; p1_in = p1_ff;
      noise_in = noise_ff; out_in = out_ff;
      rem_sh = {rem_ff, num_ff[95]};
      ysq = 66'(y_ff) * 66'(y_ff);
      lsum = 69'(e2_ff[36:32]) * 69'(LN2_Q32) + 69'((64'(e2_ff[31:0]) * 64'(LN2_Q32)) >> 32);
      prod = {p1_ff, 32'd0} + 96'(p0_ff);
      total = rw_ff[31] ? 63'(mean_ff) - 63'(noise_ff) : 63'(mean_ff) + 63'(noise_ff);

      if (acc_en) begin
         if (cnt_ff < MAX_CNT) begin
            sum_in = sum_ff + SW'(sample);
            cnt_in = cnt_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
         if (last_sample) begin
            fcnt_in = (cnt_ff < MAX_CNT) ? cnt_ff + 1'b1 : cnt_ff;
            fovf_in = ovf_in;
            rw_in = random_word;
            num_in = 96'({(cnt_ff < MAX_CNT) ? sum_in : sum_ff, 16'd0}) << (96 - DW);
            sum_in = '0; cnt_in = '0; ovf_in = 1'b0;
         end
      end

      case (phase_ff)
         P_IDLE: begin
            if (cmd.start) begin
               rem_in = '0; quo_in = '0; den_in = 64'(fcnt_ff);
               step_in = 7'(DW); capped_in = 1'b0;
               phase_in = P_MEAN;
            end
         end
         P_MEAN: begin
            num_in = num_ff << 1;
            quo_in = {quo_ff[60:0], 1'b0};
            rem_in = rem_sh[63:0];
            if (rem_sh >= 65'(den_ff)) begin
               rem_in = 64'(rem_sh - 65'(den_ff));
               quo_in[0] = 1'b1;
            end
            step_in = step_ff - 1'b1;
            if (step_ff == 7'd1) begin
               mean_in = quo_in[47:0];
               lint_in = msb; lfrac_in = '0;
               y_in = 33'({xval, 1'b0} << (5'd31 - msb)) >> 1;
               step_in = 7'd32;
               phase_in = P_LOG;
            end
         end
         P_LOG: begin
            y_in = ysq[63:31] >= 33'h1_0000_0000 ? 33'(ysq[65:32]) : ysq[63:31];
            lfrac_in = {lfrac_ff[30:0], ysq[63:31] >= 33'h1_0000_0000};
            step_in = step_ff - 1'b1;
            if (step_ff == 7'd1) begin
               e2_in = {5'd31, 32'd0} - {lint_ff, lfrac_in};
               phase_in = P_LMUL;
            end
         end
         P_LMUL: begin
            l_in = lsum[36:0];
            phase_in = P_PMUL;
         end
         P_PMUL: begin
            p0_in = 64'(value_range) * 64'(l_ff[31:0]);
            p1_in = 64'(value_range) * 64'(l_ff[36:32]);
            phase_in = P_NDIV;
            den_in = 64'(fcnt_ff) * 64'(epsilon_q16);
            step_in = 7'd97; rem_in = '0; quo_in = '0; capped_in = 1'b0;
            if (epsilon_q16 == 32'd0) begin
               noise_in = '0;
               phase_in = P_SUM;
            end
         end
         P_NDIV: begin
            if (step_ff == 7'd97) begin
               // load the dividend from the registered partial products
               num_in = prod;
               step_in = 7'd96;
            end else begin
               num_in = num_ff << 1;
               quo_in = {quo_ff[60:0], 1'b0};
               rem_in = rem_sh[63:0];
               if (rem_sh >= 65'(den_ff)) begin
                  rem_in = 64'(rem_sh - 65'(den_ff));
                  quo_in[0] = 1'b1;
               end
               if (quo_in >= NOISE_CAP) capped_in = 1'b1;
               step_in = step_ff - 1'b1;
               if (step_ff == 7'd1) begin
                  noise_in = capped_in ? NOISE_CAP : quo_in;
                  phase_in = P_SUM;
               end
            end
         end
         P_SUM: begin
            if (total > 63'sd576460752303423487) out_in = 60'sh7FF_FFFF_FFFF_FFFF;
            else if (total < -63'sd576460752303423488) out_in = 60'sh800_0000_0000_0000;
            else out_in = total[59:0];
            phase_in = P_DONE;
         end
         P_DONE: begin
            if (cmd.rsp_taken) phase_in = P_IDLE;
         end
         default: phase_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         sum_ff <= '0; cnt_ff <= '0; ovf_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         sum_ff <= sum_in; cnt_ff <= cnt_in; ovf_ff <= ovf_in;
      end
      fcnt_ff <= fcnt_in; fovf_ff <= fovf_in; rw_ff <= rw_in;
      num_ff <= num_in; rem_ff <= rem_in; den_ff <= den_in; quo_ff <= quo_in;
      step_ff <= step_in; capped_ff <= capped_in;
      mean_ff <= mean_in; lint_ff <= lint_in; lfrac_ff <= lfrac_in; y_ff <= y_in;
      e2_ff <= e2_in; l_ff <= l_in; p0_ff <= p0_in; p1_ff <= p1_in;
      noise_ff <= noise_in; out_ff <= out_in;
   end

   assign status.busy = (phase_ff != P_IDLE);
   assign status.done = (phase_ff == P_DONE);
   assign noisy_mean = out_ff;
   assign plain_mean = mean_ff;
   assign sample_count = 13'(fcnt_ff);
   assign count_overflow = fovf_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset) cnt_ff <= MAX_CNT)
      else $error("sample count beyond limit");
   a_cnt_clear: assert property (@(posedge clock) disable iff (reset)
      acc_en && last_sample |=> cnt_ff == '0) else $error("count not cleared after set");
   a_fcnt_pos: assert property (@(posedge clock) disable iff (reset)
      status.done |-> fcnt_ff != '0) else $error("finished set with zero count");
`endif
endmodule

// ===== rtl/lpm_ctrl.sv =====
// Controller: input handshake and sequencing of the finish computation.
module lpm_ctrl
   import lpm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_last,
   output logic          req_ready,
   output logic          acc_en,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);
   typedef enum logic [1:0] {S_ACC, S_START, S_WAIT} state_type;
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_ACC:   if (req_valid && req_last) state_in = S_START;
         S_START: state_in = S_WAIT;
         S_WAIT:  if (status.done && rsp_ready) state_in = S_ACC;
         default: state_in = S_ACC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_ACC;
      else state_ff <= state_in;
   end

   assign req_ready = (state_ff == S_ACC);
   assign acc_en = req_valid && req_ready;
   assign cmd.start = (state_ff == S_START);
   assign rsp_valid = (state_ff == S_WAIT) && status.done;
   assign cmd.rsp_taken = rsp_valid && rsp_ready;

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !status.busy) else $error("start while busy");
   a_no_accept: assert property (@(posedge clock) disable iff (reset)
      status.busy |-> !req_ready) else $error("accept during finish");
   a_seq: assert property (@(posedge clock) disable iff (reset)
      acc_en && req_last |=> cmd.start) else $error("start missing after last");
`endif
endmodule

// ===== rtl/laplace_private_mean.sv =====
// Top level of the Laplace-noised mean block.
// Usage:
//  req channel carries one sample per item; last_sample closes the set and
//  its random_word supplies the noise draw (bit 31 negative sign).
//  rsp channel returns one item per set: noisy mean, plain mean, count and
//  overflow flag. csr channel writes epsilon_q16 (index 0) and value_range
//  (index 1); csr_ready is always high.
// Timing:
//  A non-last sample is taken every cycle while no set is being finished.
//  After the last sample the block runs a finish sequence: a start state,
//  restoring mean division (sum width plus 16 steps, 60 at default
//  settings), 32 log2 squaring steps, two multiply steps, a dividend
//  load step, a 96-step noise division and one clamp step. Epsilon zero
//  skips the noise division. req_ready stays low until the result is
//  delivered and rises the cycle after.
// Reset clears the running sum, count and overflow flag, sets epsilon to
//  1.0 and range to 0. A stalled receiver holds the result; no new item is
//  taken until it is delivered.
module laplace_private_mean
   import lpm_pkg::*;
#(
   parameter int MAX_SAMPLES = 4096
) (
   input logic clock,
   input logic reset,
   lpm_req_if.sink   req,
   lpm_rsp_if.source rsp,
   lpm_csr_if.sink   csr
);
   logic [31:0]   eps_ff, range_ff;
   logic          acc_en;
   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
         range_ff <= '0;
      end else if (csr.valid) begin
         case (reg_index_type'(csr.index))
            REG_EPSILON: eps_ff <= csr.data;
            REG_RANGE:   range_ff <= csr.data;
            default: ;
         endcase
      end
   end

   lpm_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_last(req.last_sample), .req_ready(req.ready),
      .acc_en, .rsp_ready(rsp.ready), .rsp_valid(rsp.valid), .cmd, .status
   );

   lpm_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
      .clock, .reset, .acc_en,
      .sample(req.sample), .last_sample(req.last_sample), .random_word(req.random_word),
      .epsilon_q16(eps_ff), .value_range(range_ff), .cmd, .status,
      .noisy_mean(rsp.noisy_mean), .plain_mean(rsp.plain_mean),
      .sample_count(rsp.sample_count), .count_overflow(rsp.count_overflow)
   );
endmodule

// ===== dv/lpm_checker.sv =====
// Noisy mean checker: predicts each result from accepted items and compares it.
module lpm_checker
   import lpm_pkg::*;
#(
   parameter int MAX_SAMPLES = 4096
) (
   input  logic clock,
   input  logic reset,
   lpm_req_if   req,
   lpm_rsp_if   rsp,
   lpm_csr_if   csr,
   output int   fail_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [59:0] noisy_mean;
      logic [47:0]        plain_mean;
      logic [12:0]        sample_count;
      logic               count_overflow;
   } mean_result_type;

   localparam logic [63:0] NOISE_CAP = 64'd1 << 61;
   localparam longint OUT_MAX = (longint'(1) << 59) - 1;
   localparam longint OUT_MIN = -(longint'(1) << 59);

   mean_result_type mean_q[$];
   logic [31:0] eps_cfg, range_cfg;
   logic [63:0] acc_sum;
   int unsigned acc_count;
   logic        acc_dropped;

   assign pending_count = mean_q.size();

   // log2(x) in Q5.32 by repeated squaring of the normalized mantissa
   function automatic logic [63:0] log2_fix(logic [31:0] x);
      int n;
      logic [63:0] y, frac;
      n = 31;
      while (n > 0 && !x[n]) n--;
      y = {32'b0, x} << (31 - n);
      frac = '0;
      for (int i = 0; i < 32; i++) begin
         y = (y * y) >> 31;
         frac = frac << 1;
         if (y >= 64'h1_0000_0000) begin
            y = y >> 1;
            frac[0] = 1'b1;
         end
      end
      return (64'(n) << 32) | frac;
   endfunction

   // floor(range * l / d), held at the cap
   function automatic logic [63:0] noise_div(logic [31:0] range, logic [63:0] l,
                                             logic [63:0] d);
      logic [95:0] num;
      logic [63:0] rem, q;
      num = 96'(range) * 96'(l);
      rem = '0;
      q = '0;
      for (int i = 95; i >= 0; i--) begin
         rem = (rem << 1) | 64'(num[i]);
         q = q << 1;
         if (rem >= d) begin
            rem = rem - d;
            q[0] = 1'b1;
         end
         if (q >= NOISE_CAP) return NOISE_CAP;
      end
      return q;
   endfunction

   function automatic mean_result_type finish_set(logic [31:0] rw);
      mean_result_type res;
      logic [63:0] cnt, quo, rmd, mean, noise, e2, l;
      logic [31:0] x;
      longint total;
      cnt = 64'(acc_count);
      quo = acc_sum / cnt;
      rmd = acc_sum % cnt;
      mean = (quo << 16) | ((rmd << 16) / cnt);
      noise = '0;
      if (eps_cfg != 0) begin
         x = 32'h8000_0000 - {1'b0, rw[30:0]};
         e2 = (64'd31 << 32) - log2_fix(x);
         l = (e2 >> 32) * 64'(LN2_Q32) + ((64'(e2[31:0]) * 64'(LN2_Q32)) >> 32);
         noise = noise_div(range_cfg, l, cnt * 64'(eps_cfg));
      end
      if (rw[31]) total = longint'(mean) - longint'(noise);
      else total = longint'(mean) + longint'(noise);
      if (total > OUT_MAX) total = OUT_MAX;
      if (total < OUT_MIN) total = OUT_MIN;
      res.noisy_mean = total[59:0];
      res.plain_mean = mean[47:0];
      res.sample_count = cnt[12:0];
      res.count_overflow = acc_dropped;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      mean_result_type want;
      if (reset) begin
         eps_cfg     <= EPS_RESET;
         range_cfg   <= '0;
         acc_sum     = '0;
         acc_count   = 0;
         acc_dropped = 1'b0;
         mean_q.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            case (reg_index_type'(csr.index))
               REG_EPSILON: eps_cfg <= csr.data;
               REG_RANGE:   range_cfg <= csr.data;
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            if (acc_count < MAX_SAMPLES) begin
               acc_sum = acc_sum + 64'(req.sample);
               acc_count++;
            end else begin
               acc_dropped = 1'b1;
            end
            if (req.last_sample) begin
               mean_q.push_back(finish_set(req.random_word));
               acc_sum     = '0;
               acc_count   = 0;
               acc_dropped = 1'b0;
            end
         end
         if (rsp.valid && rsp.ready) begin
            if (mean_q.size() == 0) begin
               report_mismatch("unexpected item", 64'(rsp.plain_mean), 64'd0);
            end else begin
               want = mean_q.pop_front();
               if (rsp.noisy_mean !== want.noisy_mean)
                  report_mismatch("noisy_mean", 64'(rsp.noisy_mean), 64'(want.noisy_mean));
               if (rsp.plain_mean !== want.plain_mean)
                  report_mismatch("plain_mean", 64'(rsp.plain_mean), 64'(want.plain_mean));
               if (rsp.sample_count !== want.sample_count)
                  report_mismatch("sample_count", 64'(rsp.sample_count),
                                  64'(want.sample_count));
               if (rsp.count_overflow !== want.count_overflow)
                  report_mismatch("count_overflow", 64'(rsp.count_overflow),
                                  64'(want.count_overflow));
            end
         end
      end
   end
endmodule

// ===== dv/testbench.sv =====
// Top of the noisy mean testbench: clock, reset, stimulus, verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lpm_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic calm = 1'b0;
   int   fail_count, pending_count;
   int   quiet_cycles = 0;
   int   rsp_seen = 0;
   int   hold_left = 0;
   bit   held_once = 0;

   lpm_req_if req_if();
   lpm_rsp_if rsp_if();
   lpm_csr_if csr_if();

   laplace_private_mean u_dut (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if), .csr(csr_if)
   );

   lpm_checker u_checker (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if), .csr(csr_if),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.sample = '0;
      req_if.last_sample = 1'b0;
      req_if.random_word = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
   end

   // receiver: random stalls, plus one long hold-off after 30 results
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) rsp_seen++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (!held_once && rsp_seen == 30) begin
            held_once = 1;
            hold_left = 600;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= calm || ($urandom_range(99) >= 17);
         end
      end
   end

   // watchdog on cycles with no accepted item anywhere
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_sample(logic [31:0] s, logic lst, logic [31:0] rw);
      while (!calm && $urandom_range(99) < 17) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.sample <= s;
      req_if.last_sample <= lst;
      req_if.random_word <= rw;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_sample();
      case ($urandom_range(3))
         0: return $urandom_range(255);
         1: return 32'hFFFF_FFFF - $urandom_range(15);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_sets(int n_items);
      int sent, len;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
         for (int k = 0; k < len; k++)
            send_sample(rand_sample(), k == len - 1, $urandom);
         sent += len;
      end
   endtask

   initial begin
      logic [31:0] eps_set[4];
      logic [31:0] range_set[4];
      eps_set = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd6554};
      range_set = '{32'hFFFF_FFFF, 32'd1, 32'd1000, 32'd65535};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings give zero range, then extremes
      send_sample(32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF);
      send_sample(32'd0, 1'b1, 32'h0000_0000);
      drain();
      write_reg(REG_RANGE, 32'd255);
      send_sample(32'd10, 1'b0, 32'hFFFF_FFFF);
      send_sample(32'd20, 1'b1, 32'h8000_0000);
      send_sample(32'd7, 1'b1, 32'h4000_0000);
      send_sample(32'd7, 1'b1, 32'hC000_0000);
      send_sample(32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF);
      send_sample(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      drain();
      // tiny epsilon, huge range: noise hits the cap and the output saturates
      write_reg(REG_EPSILON, 32'd1);
      write_reg(REG_RANGE, 32'hFFFF_FFFF);
      send_sample(32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF);
      send_sample(32'd0, 1'b1, 32'hFFFF_FFFF);
      send_sample(32'd5, 1'b1, 32'h8000_0000);
      drain();
      // epsilon zero disables noise
      write_reg(REG_EPSILON, 32'd0);
      send_sample(32'd3, 1'b0, 32'd0);
      send_sample(32'd4, 1'b1, 32'hFFFF_FFFF);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         write_reg(REG_EPSILON, eps_set[ph]);
         write_reg(REG_RANGE, range_set[ph]);
         if (ph == 1) begin
            calm <= 1'b1;
            random_sets(80);
            calm <= 1'b0;
         end
         random_sets(300);
         drain();
      end

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
